@@ src/mwsd_pkg.sv @@
// Package for the moving-window standard deviation core.
// Holds default parameter values, the coarse unit factor and the control and status
// structs passed between the controller and the per-axis engines. No dependencies.
package mwsd_pkg;

   localparam int WINDOW_LEN_DEF  = 10;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COARSE_FACTOR   = 60;

   typedef struct packed {
      logic start;
      logic ack;
   } axis_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } axis_sts_type;

endpackage

@@ src/mwsd_front.sv @@
// Front end of the moving-window standard deviation core: scales coarse-flagged samples
// by the coarse unit factor with saturation and holds each word in a two-entry queue.
// Depends on mwsd_pkg.
module mwsd_front #(
   parameter int SAMPLE_BITS = mwsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [SAMPLE_BITS-1:0] req_x_sample,
   input  logic                          req_x_unit_coarse,
   input  logic signed [SAMPLE_BITS-1:0] req_y_sample,
   input  logic                          req_y_unit_coarse,
   input  logic                          push,
   output logic                          full,
   output logic signed [SAMPLE_BITS-1:0] head_x,
   output logic signed [SAMPLE_BITS-1:0] head_y,
   output logic                          head_vld,
   input  logic                          head_pop
);
   import mwsd_pkg::*;

   localparam int W     = SAMPLE_BITS;
   localparam int EW    = W + 7;
   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic signed [EW-1:0] SMAX = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] SMIN = -SMAX - EW'(1);

   logic signed [W-1:0] x_q_ff [DEPTH];
   logic signed [W-1:0] y_q_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]       count_ff;
   logic signed [W-1:0] x_scaled, y_scaled;
   logic                wr_en, rd_en;

   function automatic logic signed [W-1:0] scale(input logic signed [W-1:0] s,
                                                 input logic coarse);
      logic signed [EW-1:0] ext;
      logic signed [EW-1:0] prod;
      ext  = EW'(s);
      prod = ext * EW'(COARSE_FACTOR);
      if (!coarse) begin
         scale = s;
      end else if (prod > SMAX) begin
         scale = SMAX[W-1:0];
      end else if (prod < SMIN) begin
         scale = SMIN[W-1:0];
      end else begin
         scale = prod[W-1:0];
      end
   endfunction

   assign x_scaled = scale(req_x_sample, req_x_unit_coarse);
   assign y_scaled = scale(req_y_sample, req_y_unit_coarse);

   assign full     = (count_ff == CW'(DEPTH));
   assign head_vld = (count_ff != '0);
   assign wr_en    = push && !full;
   assign rd_en    = head_pop && head_vld;
   assign head_x   = x_q_ff[rd_ptr_ff];
   assign head_y   = y_q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_q_ff[wr_ptr_ff] <= x_scaled;
         y_q_ff[wr_ptr_ff] <= y_scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         case ({wr_en, rd_en})
            2'b10:   count_ff <= count_ff + CW'(1);
            2'b01:   count_ff <= count_ff - CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ src/mwsd_axis.sv @@
// Per-axis engine: sliding window, running sum and squared sum, a shared multiplier
// that builds N*S2 - S1^2 from partial products, and a bit-per-cycle square root.
// Depends on mwsd_pkg.
module mwsd_axis #(
   parameter int WINDOW_LEN  = mwsd_pkg::WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = mwsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mwsd_pkg::axis_ctl_type        ctl,
   output mwsd_pkg::axis_sts_type        sts,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic [SAMPLE_BITS-2:0]        deviation
);
   import mwsd_pkg::*;

   localparam int W     = SAMPLE_BITS;
   localparam int N     = WINDOW_LEN;
   localparam int NB    = $clog2(N + 1);
   localparam int SW    = W + $clog2(N);
   localparam int SQW   = 2 * W - 1 + $clog2(N);
   localparam int VW    = 2 * W - 2 + 2 * NB + 1;
   localparam int AW    = VW + 1;
   localparam int H     = (SW + 1) / 2;
   localparam int C     = (SQW + W - 1) / W;
   localparam int NSTEP = 5 + C;
   localparam int STW   = $clog2(NSTEP + 1);
   localparam int SHW   = $clog2(AW);
   localparam int CNTW  = $clog2(W);

   // Multiply steps, in issue order.
   localparam int STEP_NEW_SQ = 0;
   localparam int STEP_OLD_SQ = 1;
   localparam int STEP_LO_LO  = 2;
   localparam int STEP_HI_LO  = 3;
   localparam int STEP_HI_HI  = 4;
   localparam int STEP_CHUNK  = 5;

   localparam logic [VW-1:0] BIT_INIT = VW'(N * N) << (2 * (W - 2));

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MAC  = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_DONE = 4'b1000
   } axis_state_type;

   axis_state_type      state_ff;
   logic signed [W-1:0] win_ff [N];
   logic signed [SW-1:0] sum_ff;
   logic [SQW-1:0]      sq_ff;
   logic signed [W-1:0] new_ff, old_ff;
   logic [2*W-1:0]      prod_ff;
   logic [STW-1:0]      step_ff, app_step_ff;
   logic                app_vld_ff;
   logic [AW-1:0]       acc_ff;
   logic [VW-1:0]       root_ff, bit_ff;
   logic [CNTW-1:0]     cnt_ff;
   logic [W-2:0]        dev_ff;

   logic [W-1:0]        new_mag, old_mag, chunk, mul_a, mul_b;
   logic [SW-1:0]       sum_mag;
   logic [C*W-1:0]      sq_pad;
   logic [STW-1:0]      chunk_sel, app_chunk;
   logic [SHW-1:0]      shamt;
   logic                sub;
   logic [AW-1:0]       term, acc_in;
   logic [VW-1:0]       rem, trial;
   logic                take;

   assign new_mag   = new_ff[W-1] ? W'(-new_ff) : W'(new_ff);
   assign old_mag   = old_ff[W-1] ? W'(-old_ff) : W'(old_ff);
   assign sum_mag   = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign sq_pad    = (C * W)'(sq_ff);
   assign chunk_sel = step_ff - STW'(STEP_CHUNK);
   assign chunk     = W'(sq_pad >> (chunk_sel * W));

   always_comb begin
      case (step_ff)
         STW'(STEP_NEW_SQ): begin
            mul_a = new_mag;
            mul_b = new_mag;
         end
         STW'(STEP_OLD_SQ): begin
            mul_a = old_mag;
            mul_b = old_mag;
         end
         STW'(STEP_LO_LO): begin
            mul_a = W'(sum_mag[H-1:0]);
            mul_b = W'(sum_mag[H-1:0]);
         end
         STW'(STEP_HI_LO): begin
            mul_a = W'(sum_mag[SW-1:H]);
            mul_b = W'(sum_mag[H-1:0]);
         end
         STW'(STEP_HI_HI): begin
            mul_a = W'(sum_mag[SW-1:H]);
            mul_b = W'(sum_mag[SW-1:H]);
         end
         default: begin
            mul_a = chunk;
            mul_b = W'(N);
         end
      endcase
   end

   // The cross term of S1^2 is 2*hi*lo, hence the extra shift by one.
   assign app_chunk = app_step_ff - STW'(STEP_CHUNK);
   always_comb begin
      case (app_step_ff)
         STW'(STEP_LO_LO): begin
            shamt = '0;
            sub   = 1'b1;
         end
         STW'(STEP_HI_LO): begin
            shamt = SHW'(H + 1);
            sub   = 1'b1;
         end
         STW'(STEP_HI_HI): begin
            shamt = SHW'(2 * H);
            sub   = 1'b1;
         end
         default: begin
            shamt = SHW'(app_chunk * W);
            sub   = 1'b0;
         end
      endcase
   end

   assign term   = AW'(prod_ff) << shamt;
   assign acc_in = sub ? acc_ff - term : acc_ff + term;

   // In the root phase the accumulator holds the remainder; root and bit carry a
   // factor of N^2 so the loop yields the largest d with (N*d)^2 <= remainder.
   assign rem   = acc_ff[VW-1:0];
   assign trial = root_ff + bit_ff;
   assign take  = (rem >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         app_vld_ff <= 1'b0;
         sum_ff     <= '0;
         sq_ff      <= '0;
         for (int i = 0; i < N; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (ctl.start) begin
                  new_ff     <= sample;
                  old_ff     <= win_ff[N-1];
                  win_ff[0]  <= sample;
                  for (int i = 1; i < N; i++) begin
                     win_ff[i] <= win_ff[i-1];
                  end
                  sum_ff     <= sum_ff + SW'(sample) - SW'(win_ff[N-1]);
                  acc_ff     <= '0;
                  step_ff    <= '0;
                  app_vld_ff <= 1'b0;
                  state_ff   <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (step_ff != STW'(NSTEP)) begin
                  prod_ff     <= mul_a * mul_b;
                  app_step_ff <= step_ff;
                  app_vld_ff  <= 1'b1;
                  step_ff     <= step_ff + STW'(1);
               end else begin
                  app_vld_ff <= 1'b0;
               end
               if (app_vld_ff) begin
                  case (app_step_ff)
                     STW'(STEP_NEW_SQ): sq_ff <= sq_ff + SQW'(prod_ff);
                     STW'(STEP_OLD_SQ): sq_ff <= sq_ff - SQW'(prod_ff);
                     default:           acc_ff <= acc_in;
                  endcase
                  if (app_step_ff == STW'(NSTEP - 1)) begin
                     root_ff  <= '0;
                     bit_ff   <= BIT_INIT;
                     cnt_ff   <= CNTW'(W - 2);
                     dev_ff   <= '0;
                     state_ff <= ST_ROOT;
                  end
               end
            end
            ST_ROOT: begin
               if (take) begin
                  acc_ff  <= AW'(rem - trial);
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               dev_ff <= {dev_ff[W-3:0], take};
               bit_ff <= bit_ff >> 2;
               if (cnt_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff <= cnt_ff - CNTW'(1);
               end
            end
            ST_DONE: begin
               if (ctl.ack) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign sts.idle  = (state_ff == ST_IDLE);
   assign sts.done  = (state_ff == ST_DONE);
   assign deviation = dev_ff;

   a_ack_in_done: assert property (@(posedge clock) disable iff (reset)
      ctl.ack |-> state_ff == ST_DONE)
      else $error("axis acknowledged while no result is ready");

   a_rem_nonneg: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> !acc_ff[AW-1])
      else $error("variance numerator negative at start of root phase");

   a_root_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> cnt_ff <= CNTW'(W - 2))
      else $error("root iteration count out of range");

endmodule

@@ src/moving_window_std_deviation_core.sv @@
// Two-axis inclinometer conditioner with moving-window population standard deviation.
// Input channel: drive req_* and raise push; a word is taken on a clock edge with push
// high and full low. Each word carries an X and a Y sample (signed, 8 fraction bits)
// and a coarse-unit flag per axis that scales the sample by 60 with saturation.
// Result channel: while empty is low, rsp_* hold the oldest result; pop takes it.
// Each result holds the scaled samples and the floored population standard deviation
// of the last WINDOW_LEN scaled samples of each axis.
// The engines take one word at a time: a shared multiplier forms N*S2 - S1^2 from
// partial products, among them one per SAMPLE_BITS-wide piece of the squared sum
// (3 pieces at the defaults), and the square root then resolves one result bit per
// cycle. A new word starts only once both engines are idle again.
// A two-entry input queue takes new words while the engines work or a result waits;
// when pop is held low the result register holds, the engines stop in their final
// state and full rises once the queue is full.
// Reset clears the windows and sums and empties the queue and result register; the
// first words see a window padded with zero samples.
// Depends on mwsd_pkg, mwsd_front and mwsd_axis.
module moving_window_std_deviation_core #(
   parameter int WINDOW_LEN  = mwsd_pkg::WINDOW_LEN_DEF,
   parameter int SAMPLE_BITS = mwsd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [SAMPLE_BITS-1:0] req_x_sample,
   input  logic                          req_x_unit_coarse,
   input  logic signed [SAMPLE_BITS-1:0] req_y_sample,
   input  logic                          req_y_unit_coarse,
   input  logic                          push,
   output logic                          full,
   output logic signed [SAMPLE_BITS-1:0] rsp_x_value,
   output logic [SAMPLE_BITS-2:0]        rsp_x_deviation,
   output logic signed [SAMPLE_BITS-1:0] rsp_y_value,
   output logic [SAMPLE_BITS-2:0]        rsp_y_deviation,
   output logic                          empty,
   input  logic                          pop
);
   import mwsd_pkg::*;

   localparam int W = SAMPLE_BITS;

   logic signed [W-1:0] head_x, head_y;
   logic                head_vld;
   axis_ctl_type        ctl;
   axis_sts_type        x_sts, y_sts;
   logic [W-2:0]        x_dev, y_dev;
   logic signed [W-1:0] x_val_ff, y_val_ff;
   logic signed [W-1:0] rsp_x_value_ff, rsp_y_value_ff;
   logic [W-2:0]        rsp_x_dev_ff, rsp_y_dev_ff;
   logic                rsp_vld_ff;
   logic                load;

   mwsd_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_x_sample      (req_x_sample),
      .req_x_unit_coarse (req_x_unit_coarse),
      .req_y_sample      (req_y_sample),
      .req_y_unit_coarse (req_y_unit_coarse),
      .push              (push),
      .full              (full),
      .head_x            (head_x),
      .head_y            (head_y),
      .head_vld          (head_vld),
      .head_pop          (ctl.start)
   );

   mwsd_axis #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (x_sts),
      .sample    (head_x),
      .deviation (x_dev)
   );

   mwsd_axis #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (y_sts),
      .sample    (head_y),
      .deviation (y_dev)
   );

   // Both engines run in lockstep, so one start and one acknowledge serve both.
   assign load      = x_sts.done && y_sts.done && (!rsp_vld_ff || pop);
   assign ctl.start = head_vld && x_sts.idle && y_sts.idle;
   assign ctl.ack   = load;

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_val_ff <= head_x;
         y_val_ff <= head_y;
      end
      if (load) begin
         rsp_x_value_ff <= x_val_ff;
         rsp_y_value_ff <= y_val_ff;
         rsp_x_dev_ff   <= x_dev;
         rsp_y_dev_ff   <= y_dev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load) begin
         rsp_vld_ff <= 1'b1;
      end else if (pop) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign empty           = !rsp_vld_ff;
   assign rsp_x_value     = rsp_x_value_ff;
   assign rsp_y_value     = rsp_y_value_ff;
   assign rsp_x_deviation = rsp_x_dev_ff;
   assign rsp_y_deviation = rsp_y_dev_ff;

   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_sts.done == y_sts.done && x_sts.idle == y_sts.idle)
      else $error("axis engines out of step");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> !x_sts.idle && !y_sts.idle && !x_sts.done)
      else $error("engines did not leave idle after a start");

endmodule
